FILE: design/dtpg_pkg.sv
// Shared types, codes and constants of the display test pattern generator.
package dtpg_pkg;

    localparam int unsigned SEGMENT_COUNT = 6;
    localparam int unsigned COL_W         = 12;
    localparam int unsigned CHAN_W        = 8;
    localparam int unsigned PART_W        = 10;
    localparam int unsigned CNT_W         = 4;

    // Screen width divided by six: multiply by a scaled reciprocal, exact for 12-bit widths.
    localparam logic [15:0] RECIP_SIX   = 16'd43691;
    localparam int unsigned RECIP_SHIFT = 18;

    localparam logic [COL_W-1:0]  WIDTH_RESET = 12'd320;
    localparam logic [CHAN_W-1:0] FULL        = 8'hFF;

    localparam logic [CNT_W-1:0] SEG_STEPS  = 4'd12;
    localparam logic [CNT_W-1:0] RAMP_STEPS = 4'd8;

    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0]  REG_COLUMNS = 1'b0;

    typedef enum logic [2:0] {
        STG_RED     = 3'd0,
        STG_GREEN   = 3'd1,
        STG_BLUE    = 3'd2,
        STG_PALETTE = 3'd3,
        STG_GRAY    = 3'd4,
        STG_DONE    = 3'd5
    } t_stage;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_DIV_SEG,
        CS_DIV_RAMP,
        CS_FINISH
    } t_ctl_state;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic load_seg;
        logic load_gray;
        logic load_ramp;
        logic step;
        logic write_out;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic need_palette;
        logic need_gray;
    } t_dp_status;

endpackage

FILE: design/dtpg_item_if.sv
// Input channel: pixel request or button press.
interface dtpg_item_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [dtpg_pkg::COL_W-1:0]     column;

    modport source (output valid, output command, output column, input ready);
    modport sink   (input valid, input command, input column, output ready);
endinterface

FILE: design/dtpg_result_if.sv
// Result channel: column colour and stage status.
interface dtpg_result_if;
    logic                           valid;
    logic                           ready;
    logic [dtpg_pkg::CHAN_W-1:0]    red;
    logic [dtpg_pkg::CHAN_W-1:0]    green;
    logic [dtpg_pkg::CHAN_W-1:0]    blue;
    logic                           painted;
    logic [2:0]                     current_stage;
    logic                           test_done;

    modport source (output valid, output red, output green, output blue, output painted,
                    output current_stage, output test_done, input ready);
    modport sink   (input valid, input red, input green, input blue, input painted,
                    input current_stage, input test_done, output ready);
endinterface

FILE: design/dtpg_ctrl.sv
// Controller state machine: sequences acceptance, divider steps and result write.
module dtpg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    input  dtpg_pkg::t_dp_status  i_status,
    output dtpg_pkg::t_dp_cmd     o_cmd
);

    dtpg_pkg::t_ctl_state           r_state, n_state;
    logic [dtpg_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;
    logic                           w_slot_free;
    logic                           w_last;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_last      = (r_cnt == dtpg_pkg::CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            dtpg_pkg::CS_IDLE: begin
                if (i_in_valid) begin
                    n_state = dtpg_pkg::CS_DISPATCH;
                end
            end
            dtpg_pkg::CS_DISPATCH: begin
                if (i_status.need_palette) begin
                    n_state = dtpg_pkg::CS_DIV_SEG;
                    n_cnt   = dtpg_pkg::SEG_STEPS;
                end else if (i_status.need_gray) begin
                    n_state = dtpg_pkg::CS_DIV_RAMP;
                    n_cnt   = dtpg_pkg::RAMP_STEPS;
                end else begin
                    n_state = dtpg_pkg::CS_FINISH;
                end
            end
            dtpg_pkg::CS_DIV_SEG: begin
                n_cnt = r_cnt - dtpg_pkg::CNT_W'(1);
                if (w_last) begin
                    n_state = dtpg_pkg::CS_DIV_RAMP;
                    n_cnt   = dtpg_pkg::RAMP_STEPS;
                end
            end
            dtpg_pkg::CS_DIV_RAMP: begin
                n_cnt = r_cnt - dtpg_pkg::CNT_W'(1);
                if (w_last) begin
                    n_state = dtpg_pkg::CS_FINISH;
                end
            end
            dtpg_pkg::CS_FINISH: begin
                if (w_slot_free) begin
                    n_state = dtpg_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = dtpg_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dtpg_pkg::CS_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            dtpg_pkg::CS_DISPATCH: begin
                o_cmd.load_seg  = i_status.need_palette;
                o_cmd.load_gray = !i_status.need_palette && i_status.need_gray;
            end
            dtpg_pkg::CS_DIV_SEG: begin
                o_cmd.step      = 1'b1;
                o_cmd.load_ramp = w_last;
            end
            dtpg_pkg::CS_DIV_RAMP: begin
                o_cmd.step = 1'b1;
            end
            dtpg_pkg::CS_FINISH: begin
                o_cmd.write_out = w_slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.write_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtpg_pkg::CS_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: design/dtpg_datapath.sv
// Datapath: width and stage registers, shared restoring divider, color mapping.
module dtpg_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtpg_pkg::t_dp_cmd             i_cmd,
    output dtpg_pkg::t_dp_status          o_status,
    input  logic                          i_cfg_we,
    input  logic [dtpg_pkg::COL_W-1:0]    i_cfg_width,
    output logic [dtpg_pkg::COL_W-1:0]    o_width,
    input  logic                          i_command,
    input  logic [dtpg_pkg::COL_W-1:0]    i_column,
    output logic [dtpg_pkg::CHAN_W-1:0]   o_red,
    output logic [dtpg_pkg::CHAN_W-1:0]   o_green,
    output logic [dtpg_pkg::CHAN_W-1:0]   o_blue,
    output logic                          o_painted,
    output logic [2:0]                    o_current_stage,
    output logic                          o_test_done
);

    localparam int unsigned CW = dtpg_pkg::COL_W;
    localparam int unsigned HW = dtpg_pkg::CHAN_W;

    logic [CW-1:0]            r_width;
    dtpg_pkg::t_stage         r_stage;
    logic                     r_cmd;
    logic [CW-1:0]            r_col;
    logic [CW-1:0]            r_rem;
    logic [CW-1:0]            r_quo;
    logic [CW-1:0]            r_div;
    logic [2:0]               r_seg;
    logic                     r_seg_ok;
    logic [HW-1:0]            r_red, r_green, r_blue;
    logic                     r_painted;
    logic [2:0]               r_cur_stage;
    logic                     r_done;

    logic [CW+15:0]           w_prod;
    logic [dtpg_pkg::PART_W-1:0] w_part;
    logic                     w_onscreen;
    logic [CW:0]              w_trial;
    logic                     w_ge;
    logic [CW:0]              w_diff;
    logic [HW-1:0]            w_k;
    logic [HW-1:0]            n_red, n_green, n_blue;
    logic                     n_painted;

    // part size = width / 6
    assign w_prod     = r_width * dtpg_pkg::RECIP_SIX;
    assign w_part     = w_prod[CW+15 -: dtpg_pkg::PART_W];
    assign w_onscreen = (r_col < r_width);

    assign o_status.need_palette = !r_cmd && w_onscreen && (r_stage == dtpg_pkg::STG_PALETTE)
                                   && (w_part != '0);
    assign o_status.need_gray    = !r_cmd && w_onscreen && (r_stage == dtpg_pkg::STG_GRAY);

    // One restoring step: shift the next dividend bit into the remainder.
    assign w_trial = {r_rem, r_quo[CW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_k     = r_quo[HW-1:0];

    always_comb begin
        n_red     = '0;
        n_green   = '0;
        n_blue    = '0;
        n_painted = 1'b0;
        if (!r_cmd && w_onscreen) begin
            case (r_stage)
                dtpg_pkg::STG_RED: begin
                    n_red     = dtpg_pkg::FULL;
                    n_painted = 1'b1;
                end
                dtpg_pkg::STG_GREEN: begin
                    n_green   = dtpg_pkg::FULL;
                    n_painted = 1'b1;
                end
                dtpg_pkg::STG_BLUE: begin
                    n_blue    = dtpg_pkg::FULL;
                    n_painted = 1'b1;
                end
                dtpg_pkg::STG_PALETTE: begin
                    if ((w_part != '0) && r_seg_ok) begin
                        n_painted = 1'b1;
                        case (r_seg)
                            3'd0: begin
                                n_red = dtpg_pkg::FULL; n_green = w_k;
                            end
                            3'd1: begin
                                n_red = dtpg_pkg::FULL - w_k; n_green = dtpg_pkg::FULL;
                            end
                            3'd2: begin
                                n_green = dtpg_pkg::FULL; n_blue = w_k;
                            end
                            3'd3: begin
                                n_green = dtpg_pkg::FULL - w_k; n_blue = dtpg_pkg::FULL;
                            end
                            3'd4: begin
                                n_red = w_k; n_blue = dtpg_pkg::FULL;
                            end
                            default: begin
                                n_red = dtpg_pkg::FULL; n_blue = dtpg_pkg::FULL - w_k;
                            end
                        endcase
                    end
                end
                dtpg_pkg::STG_GRAY: begin
                    n_red     = w_k;
                    n_green   = w_k;
                    n_blue    = w_k;
                    n_painted = 1'b1;
                end
                default: begin
                    n_painted = 1'b0;
                end
            endcase
        end
    end

    // Control state: width register and stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= dtpg_pkg::WIDTH_RESET;
            r_stage <= dtpg_pkg::STG_RED;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_width;
            end
            if (i_cmd.accept && i_command && (r_stage < dtpg_pkg::STG_DONE)) begin
                r_stage <= dtpg_pkg::t_stage'(r_stage + 3'd1);
            end
        end
    end

    // Payload: latched item, divider, result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_col <= i_column;
        end
        if (i_cmd.load_seg) begin
            r_rem <= '0;
            r_quo <= r_col;
            r_div <= CW'(w_part);
        end else if (i_cmd.load_gray) begin
            r_rem <= r_col;
            r_quo <= '0;
            r_div <= r_width;
        end else if (i_cmd.load_ramp) begin
            // Last segment step: keep the remainder, clear the quotient so the
            // ramp runs on with zero bits shifted in.
            r_rem <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            r_quo <= '0;
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            r_quo <= {r_quo[CW-2:0], w_ge};
        end
        // Capture the segment from the quotient completed by the last step.
        if (i_cmd.load_ramp) begin
            r_seg    <= {r_quo[1:0], w_ge};
            r_seg_ok <= ({r_quo[CW-2:0], w_ge} < CW'(dtpg_pkg::SEGMENT_COUNT));
        end
        if (i_cmd.write_out) begin
            r_red       <= n_red;
            r_green     <= n_green;
            r_blue      <= n_blue;
            r_painted   <= n_painted;
            r_cur_stage <= r_stage;
            r_done      <= (r_stage >= dtpg_pkg::STG_DONE);
        end
    end

    assign o_width         = r_width;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;
    assign o_painted       = r_painted;
    assign o_current_stage = r_cur_stage;
    assign o_test_done     = r_done;

endmodule

FILE: design/display_test_pattern_generator_top.sv
// Top level of the display test pattern generator: channels, register port, submodules.
//
// Usage:
//   i_item (valid/ready) carries one beat per request: command 0 asks for the
//   color of a column in the current stage, command 1 is a button press that
//   advances the stage (red, green, blue, hue palette, gray ramp, done).
//   o_result (valid/ready) returns one beat per input beat: color, painted
//   flag, stage after the item and the done flag.
//   The APB port holds the screen column count at byte address 0 (reset 320);
//   write it only while the block is idle. pready is tied high.
// Timing:
//   One item at a time. After the accepting edge the item passes dispatch,
//   then goes straight to the result write for solid stages, presses and
//   off-screen columns, through 8 divider steps for gray columns, and through
//   12 steps for the segment and 8 for the ramp for palette columns. Input is
//   ready again the cycle after that write, so the shared divider sets the pace.
// Reset and stall:
//   Synchronous active-low reset returns to the red stage with no result
//   pending. A stalled result holds in the output register while the next
//   item is taken and computed; only its final write waits for the slot.
module display_test_pattern_generator_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    dtpg_item_if.sink                            i_item,
    dtpg_result_if.source                        o_result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dtpg_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    dtpg_pkg::t_dp_cmd               w_cmd;
    dtpg_pkg::t_dp_status            w_status;
    logic                            w_cfg_hit;
    logic                            w_cfg_we;
    logic [dtpg_pkg::COL_W-1:0]      w_width;

    // Register decode: word index is the address bit above the byte offset.
    assign pready    = 1'b1;
    assign w_cfg_hit = (paddr[dtpg_pkg::PADDR_W-1] == dtpg_pkg::REG_COLUMNS);
    assign w_cfg_we  = psel && penable && pwrite && pready && w_cfg_hit;
    assign prdata    = w_cfg_hit ? {{(32 - dtpg_pkg::COL_W){1'b0}}, w_width} : 32'd0;

    dtpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dtpg_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_width     (pwdata[dtpg_pkg::COL_W-1:0]),
        .o_width         (w_width),
        .i_command       (i_item.command),
        .i_column        (i_item.column),
        .o_red           (o_result.red),
        .o_green         (o_result.green),
        .o_blue          (o_result.blue),
        .o_painted       (o_result.painted),
        .o_current_stage (o_result.current_stage),
        .o_test_done     (o_result.test_done)
    );

endmodule
